/* src/rsd_pkg.sv */
// Shared types and constants of the record segment deframer.
// Holds the register map, segment tags, marker bytes and the configuration bundle.
package rsd_pkg;

	localparam int unsigned LEN_BITS_DEF = 32;
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned TAG_W        = 3;
	localparam int unsigned REG_W        = 32;
	localparam int unsigned REG_IDX_W    = 2;
	localparam int unsigned MARKER_LEN   = 5;

	// Register indexes of the configuration port.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_SYS_META_LEN = 2'd0,
		REG_APP_META_LEN = 2'd1,
		REG_PAYLOAD_LEN  = 2'd2,
		REG_CONTENT_LEN  = 2'd3
	} reg_idx_t;

	// Segment tags carried with every output word.
	typedef enum logic [TAG_W-1:0] {
		TAG_SYS  = 3'd0,
		TAG_APP  = 3'd1,
		TAG_PAY  = 3'd2,
		TAG_MARK = 3'd3,
		TAG_DROP = 3'd4
	} tag_t;

	typedef struct packed {
		logic [REG_W-1:0] sys_meta_length;
		logic [REG_W-1:0] app_meta_length;
		logic [REG_W-1:0] payload_length;
		logic [REG_W-1:0] content_length;
	} cfg_t;

	// Expected byte of the separator "BREAK" at a given position.
	function automatic logic [BYTE_W-1:0] marker_byte(input logic [2:0] pos);
		logic [BYTE_W-1:0] b;
		unique case (pos)
			3'd0:    b = 8'h42;
			3'd1:    b = 8'h52;
			3'd2:    b = 8'h45;
			3'd3:    b = 8'h41;
			default: b = 8'h4B;
		endcase
		return b;
	endfunction

endpackage

/* src/rsd_if.sv */
// Stream interfaces of the record segment deframer: input bytes and tagged output words.
// Depends on rsd_pkg for the field widths.
interface rsd_byte_if;
	logic                      valid;
	logic                      ready;
	logic [rsd_pkg::BYTE_W-1:0] data_byte;
	logic                      chunk_end;

	modport source (output valid, output data_byte, output chunk_end, input ready);
	modport sink   (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface rsd_seg_if;
	logic                      valid;
	logic                      ready;
	logic [rsd_pkg::BYTE_W-1:0] out_byte;
	logic [rsd_pkg::TAG_W-1:0]  segment_tag;
	logic                      segment_last;
	logic                      error_flag;
	logic                      complete_flag;

	modport source (output valid, output out_byte, output segment_tag, output segment_last,
		output error_flag, output complete_flag, input ready);
	modport sink   (input valid, input out_byte, input segment_tag, input segment_last,
		input error_flag, input complete_flag, output ready);
endinterface

/* src/rsd_cfg_regs.sv */
// Configuration register file of the record segment deframer.
// Depends on rsd_pkg for the register map and the configuration bundle.
module rsd_cfg_regs
	import rsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SYS_META_LEN: cfg_q.sys_meta_length <= cfg_wdata;
				REG_APP_META_LEN: cfg_q.app_meta_length <= cfg_wdata;
				REG_PAYLOAD_LEN:  cfg_q.payload_length  <= cfg_wdata;
				REG_CONTENT_LEN:  cfg_q.content_length  <= cfg_wdata;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/rsd_parser.sv */
// Segment tracker of the record segment deframer: input register, one step of
// segment logic and the output register. Depends on rsd_pkg and the stream interfaces.
module rsd_parser
	import rsd_pkg::*;
#(
	parameter int unsigned LEN_BITS = LEN_BITS_DEF
)(
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	rsd_byte_if.sink      byte_ch,
	rsd_seg_if.source     seg_ch
);

	typedef logic [LEN_BITS-1:0] len_t;

	typedef enum logic [2:0] {
		SEG_SYS  = 3'd0,
		SEG_BRK1 = 3'd1,
		SEG_APP  = 3'd2,
		SEG_BRK2 = 3'd3,
		SEG_PAY  = 3'd4,
		SEG_BRK3 = 3'd5,
		SEG_DONE = 3'd6
	} seg_t;

	// Input stage.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              chunk_end_s1;

	// Output stage.
	logic              valid_s2;
	logic [BYTE_W-1:0] byte_s2;
	tag_t              tag_s2;
	logic              last_s2;
	logic              err_s2;
	logic              complete_s2;

	// Record state.
	seg_t seg_q;
	len_t off_q;
	len_t total_q;
	logic err_q;

	logic adv;
	logic take;

	len_t len_sys, len_app, len_pay, len_content;
	seg_t cur_seg, seg_n;
	len_t cur_off, off_n, off_inc, cur_len, total_n;
	logic [2:0] pos;
	logic err_n, last_n, complete_n;
	tag_t tag_n;

	assign len_sys     = len_t'(cfg.sys_meta_length);
	assign len_app     = len_t'(cfg.app_meta_length);
	assign len_pay     = len_t'(cfg.payload_length);
	assign len_content = len_t'(cfg.content_length);

	assign adv  = valid_s1 && (!valid_s2 || seg_ch.ready);
	assign take = byte_ch.valid && byte_ch.ready;
	assign byte_ch.ready = !valid_s1 || adv;

	always_comb begin
		seg_n      = seg_q;
		off_n      = off_q;
		err_n      = err_q;
		tag_n      = TAG_DROP;
		last_n     = 1'b0;
		complete_n = 1'b0;
		cur_seg    = seg_q;
		cur_off    = off_q;
		cur_len    = len_pay;
		off_inc    = '0;
		pos        = 3'd4;
		total_n    = (total_q != '1) ? total_q + len_t'(1) : total_q;

		if (!err_q) begin
			// An empty data segment is stepped over into the marker after it.
			unique case (seg_q)
				SEG_SYS: if (off_q >= len_sys) begin cur_seg = SEG_BRK1; cur_off = '0; end
				SEG_APP: if (off_q >= len_app) begin cur_seg = SEG_BRK2; cur_off = '0; end
				SEG_PAY: if (off_q >= len_pay) begin cur_seg = SEG_BRK3; cur_off = '0; end
				default: ;
			endcase

			unique case (cur_seg)
				SEG_SYS: cur_len = len_sys;
				SEG_APP: cur_len = len_app;
				default: cur_len = len_pay;
			endcase

			off_inc = cur_off + len_t'(1);
			pos     = (cur_off < len_t'(MARKER_LEN)) ? cur_off[2:0] : 3'd4;
			seg_n   = cur_seg;
			off_n   = cur_off;

			unique case (cur_seg)
				SEG_SYS, SEG_APP, SEG_PAY: begin
					tag_n = (cur_seg == SEG_SYS) ? TAG_SYS :
						(cur_seg == SEG_APP) ? TAG_APP : TAG_PAY;
					if (off_inc >= cur_len) begin
						last_n = 1'b1;
						off_n  = '0;
						seg_n  = (cur_seg == SEG_SYS) ? SEG_BRK1 :
							(cur_seg == SEG_APP) ? SEG_BRK2 : SEG_BRK3;
					end else begin
						off_n = off_inc;
					end
				end
				SEG_BRK1, SEG_BRK2, SEG_BRK3: begin
					if (byte_s1 != marker_byte(pos)) begin
						err_n = 1'b1;
					end else begin
						tag_n = TAG_MARK;
						if (pos == 3'd4) begin
							last_n = 1'b1;
							off_n  = '0;
							seg_n  = (cur_seg == SEG_BRK1) ? SEG_APP :
								(cur_seg == SEG_BRK2) ? SEG_PAY : SEG_DONE;
						end else begin
							off_n = len_t'(pos) + len_t'(1);
						end
					end
				end
				default: begin
					// Anything past the final marker breaks the record.
					seg_n = SEG_DONE;
					err_n = 1'b1;
				end
			endcase

			if (chunk_end_s1) begin
				if (seg_n != SEG_DONE && total_n >= len_content) begin
					err_n = 1'b1;
				end
				if (seg_n == SEG_DONE && !err_n) begin
					complete_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			seg_q    <= SEG_SYS;
			off_q    <= '0;
			total_q  <= '0;
			err_q    <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				seg_q    <= seg_n;
				off_q    <= off_n;
				total_q  <= total_n;
				err_q    <= err_n;
			end else if (seg_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1      <= byte_ch.data_byte;
			chunk_end_s1 <= byte_ch.chunk_end;
		end
		if (adv) begin
			byte_s2     <= byte_s1;
			tag_s2      <= tag_n;
			last_s2     <= last_n;
			err_s2      <= err_n;
			complete_s2 <= complete_n;
		end
	end

	assign seg_ch.valid         = valid_s2;
	assign seg_ch.out_byte      = byte_s2;
	assign seg_ch.segment_tag   = tag_s2;
	assign seg_ch.segment_last  = last_s2;
	assign seg_ch.error_flag    = err_s2;
	assign seg_ch.complete_flag = complete_s2;

endmodule

/* src/record_segment_deframer.sv */
// Top level of the record segment deframer.
// Depends on rsd_pkg, the stream interfaces, rsd_cfg_regs and rsd_parser.
//
//   Channel   Direction  Word contents
//   byte_ch   in         data_byte[7:0], chunk_end
//   seg_ch    out        out_byte[7:0], segment_tag[2:0], segment_last, error_flag,
//                        complete_flag
//   cfg_*     in         cfg_wr_en, cfg_index[1:0], cfg_wdata[31:0] (write only)
//
// One word is accepted per cycle while seg_ch does not stall; each word reaches
// seg_ch through an input register and an output register.
// The segment step between those registers updates the segment state, offset,
// byte total and error flag.
// Reset zeroes all but the data path registers and puts the tracker at the start of the
// system metadata segment. A stalled seg_ch holds its word; the input register
// keeps taking a word as long as the output register is free or being drained.
module record_segment_deframer
	import rsd_pkg::*;
#(
	parameter int unsigned LEN_BITS = LEN_BITS_DEF
)(
	input  logic                 clk,
	input  logic                 arst_n,
	rsd_byte_if.sink             byte_ch,
	rsd_seg_if.source            seg_ch,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata
);

	// Register lengths are used in their low LEN_BITS bits.
	cfg_t cfg;

	rsd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The parser tags each byte with its segment, checks the "BREAK" markers and
	// keeps the sticky error; after an error every byte is marked discarded.
	rsd_parser #(
		.LEN_BITS (LEN_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.byte_ch (byte_ch),
		.seg_ch  (seg_ch)
	);

endmodule

/* verif/rsd_frame_checker.sv */
// Checker of the record segment deframer: watches the byte, word and register ports.
// Predicts every tagged word and compares it field by field. Depends on rsd_pkg and rsd_if.
`timescale 1ns / 1ps
module rsd_frame_checker
	import rsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	rsd_byte_if                  byte_ch,
	rsd_seg_if                   seg_ch,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	output int                   errors,
	output int                   pending
);

	localparam int unsigned LW = LEN_BITS_DEF;
	localparam logic [8*MARKER_LEN-1:0] BREAK_TEXT = "BREAK";

	typedef enum logic [2:0] {
		ST_SYS, ST_BRK1, ST_APP, ST_BRK2, ST_PAY, ST_BRK3, ST_DONE
	} seg_state_t;

	typedef struct {
		logic [BYTE_W-1:0] out_byte;
		tag_t              tag;
		logic              last;
		logic              err;
		logic              cmpl;
	} seg_word_t;

	cfg_t          regs;
	seg_state_t    seg;
	logic [LW-1:0] offs;
	logic [LW-1:0] total;
	logic          err;
	seg_word_t     words_due[$];

	function automatic logic is_data(input seg_state_t st);
		return st == ST_SYS || st == ST_APP || st == ST_PAY;
	endfunction

	function automatic logic [LW-1:0] data_len(input seg_state_t st);
		case (st)
			ST_SYS:  return regs.sys_meta_length[LW-1:0];
			ST_APP:  return regs.app_meta_length[LW-1:0];
			default: return regs.payload_length[LW-1:0];
		endcase
	endfunction

	// Advances the segment tracker by one byte and returns the word it should produce.
	function automatic seg_word_t frame_byte(input logic [BYTE_W-1:0] b, input logic ce);
		seg_word_t  w;
		logic [2:0] pos;
		w.out_byte = b;
		w.tag      = TAG_DROP;
		w.last     = 1'b0;
		w.cmpl     = 1'b0;
		if (total != '1)
			total = total + 1'b1;
		if (!err) begin
			while (is_data(seg) && offs >= data_len(seg)) begin
				seg  = seg_state_t'(seg + 3'd1);
				offs = '0;
			end
			if (is_data(seg)) begin
				case (seg)
					ST_SYS:  w.tag = TAG_SYS;
					ST_APP:  w.tag = TAG_APP;
					default: w.tag = TAG_PAY;
				endcase
				offs = offs + 1'b1;
				if (offs >= data_len(seg)) begin
					w.last = 1'b1;
					seg    = seg_state_t'(seg + 3'd1);
					offs   = '0;
				end
			end else if (seg != ST_DONE) begin
				pos = (offs < MARKER_LEN) ? offs[2:0] : 3'd4;
				if (b != BREAK_TEXT[8*(4-pos) +: 8]) begin
					err = 1'b1;
				end else begin
					w.tag = TAG_MARK;
					offs  = {{(LW-3){1'b0}}, pos} + 1'b1;
					if (offs >= MARKER_LEN) begin
						w.last = 1'b1;
						seg    = seg_state_t'(seg + 3'd1);
						offs   = '0;
					end
				end
			end else begin
				err = 1'b1;
			end
			if (ce) begin
				if (seg != ST_DONE && total >= regs.content_length[LW-1:0])
					err = 1'b1;
				if (seg == ST_DONE && !err)
					w.cmpl = 1'b1;
			end
		end
		w.err = err;
		return w;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		seg_word_t want;
		if (!arst_n) begin
			regs    = '0;
			seg     = ST_SYS;
			offs    = '0;
			total   = '0;
			err     = 1'b0;
			errors  = 0;
			words_due.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (reg_idx_t'(cfg_index))
					REG_SYS_META_LEN: regs.sys_meta_length = cfg_wdata;
					REG_APP_META_LEN: regs.app_meta_length = cfg_wdata;
					REG_PAYLOAD_LEN:  regs.payload_length  = cfg_wdata;
					REG_CONTENT_LEN:  regs.content_length  = cfg_wdata;
					default: ;
				endcase
			end
			if (byte_ch.valid && byte_ch.ready)
				words_due.push_back(frame_byte(byte_ch.data_byte, byte_ch.chunk_end));
			if (seg_ch.valid && seg_ch.ready) begin
				if (words_due.size() == 0) begin
					$error("word with nothing expected: out_byte %0d", seg_ch.out_byte);
					errors++;
				end else begin
					want = words_due.pop_front();
					check_field("out_byte", want.out_byte, seg_ch.out_byte);
					check_field("segment_tag", want.tag, seg_ch.segment_tag);
					check_field("segment_last", want.last, seg_ch.segment_last);
					check_field("error_flag", want.err, seg_ch.error_flag);
					check_field("complete_flag", want.cmpl, seg_ch.complete_flag);
				end
			end
			pending <= words_due.size();
		end
	end

endmodule

/* verif/record_segment_deframer_tb.sv */
// Top of the record segment deframer testbench: clock, reset, stimulus and verdict.
// Depends on rsd_pkg, rsd_if, the block itself and rsd_frame_checker.
`timescale 1ns / 1ps
module record_segment_deframer_tb;
	import rsd_pkg::*;

	// Far above the slowest legal run: about 600 words, each behind a long sender
	// gap and a long receiver stall, plus the long hold-off and the drains.
	localparam int LIMIT = 300000;
	localparam logic [8*MARKER_LEN-1:0] BREAK_TEXT = "BREAK";

	// Ways the one record of the run is allowed to end.
	localparam int END_COMPLETE = 0;
	localparam int END_BAD_MARK = 1;
	localparam int END_SHORT    = 2;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_wdata;
	int                   errors;
	int                   pending;
	int                   cycles = 0;
	int                   sent = 0;
	bit                   hold_req = 1'b0;

	rsd_byte_if byte_ch();
	rsd_seg_if  seg_ch();

	always #1 clk = ~clk;

	record_segment_deframer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.seg_ch    (seg_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	rsd_frame_checker i_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.seg_ch    (seg_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	// Idle stretches: mostly none or short, now and then a long one.
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offers one word and returns at the edge where it is taken. When no gap is
	// drawn, valid simply stays high from the previous word.
	task automatic send_word(input logic [BYTE_W-1:0] b, input logic ce);
		int g;
		g = pause_len();
		if (g > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.chunk_end <= ce;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	// Sends the separator "BREAK"; only its last byte gets the chosen chunk end.
	task automatic send_marker(input logic ce_last);
		int k;
		for (k = 0; k < MARKER_LEN; k++)
			send_word(BREAK_TEXT[8*(4-k) +: 8],
				(k == MARKER_LEN - 1) ? ce_last : ($urandom_range(0, 5) == 0));
	endtask

	// Leaves write enable high; the caller lowers it after its last write.
	task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	// Stops offering and waits until every word sent has come out of the pipeline,
	// plus a little margin, so registers may be written.
	task automatic settle();
		byte_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, free-running stretches, and once a long hold-off
	// while the sender keeps offering, so both pipeline registers fill up and the
	// block has to refuse input.
	initial begin : receiver
		bit hold_done;
		int g;
		hold_done    = 1'b0;
		seg_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				seg_ch.ready <= 1'b0;
				repeat (150) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				g = pause_len();
				seg_ch.ready <= 1'b0;
				repeat (g + 1) @(posedge clk);
			end else begin
				seg_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Stimulus. Reset is applied once, and the block stays done or in error for
	// good after that, so the run is built around one long record. Its lengths
	// are rewritten between phases while the block is idle, and the run ends in
	// one of three ways drawn at random: a clean completion followed by stray
	// bytes, a broken separator, or a chunk end that finds the record short.
	initial begin : stimulus
		int ending;
		int n_sys;
		int n_more;
		int app_len;
		int pay_len;
		int cut;
		int pre;
		int i;
		logic [BYTE_W-1:0] bad;

		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.chunk_end = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_index         = REG_SYS_META_LEN;
		cfg_wdata         = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		ending  = $urandom_range(END_COMPLETE, END_SHORT);
		// An empty application segment must be skipped straight to the next separator.
		app_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
		pay_len = $urandom_range(300, 420);
		n_sys   = $urandom_range(20, 60);
		cut     = $urandom_range(pay_len / 2, pay_len - 1);

		// System metadata starts at the largest length, so it cannot end by itself,
		// and the content length is out of reach so chunk ends are harmless.
		write_reg(REG_SYS_META_LEN, '1);
		write_reg(REG_APP_META_LEN, app_len);
		write_reg(REG_PAYLOAD_LEN, pay_len);
		write_reg(REG_CONTENT_LEN, '1);
		cfg_wr_en <= 1'b0;

		// Directed opening: byte extremes with and without a chunk end.
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b1);
		for (i = 4; i < n_sys; i++)
			send_word($urandom_range(0, 255), $urandom_range(0, 7) == 0);
		settle();

		// Shrink the system metadata length mid-segment. Either it drops to or below
		// the bytes already taken, so the segment closes without a last flag, or it
		// leaves a few more bytes and the final one carries the last flag.
		if ($urandom_range(0, 1)) begin
			write_reg(REG_SYS_META_LEN, $urandom_range(0, 1) ? 0 : $urandom_range(0, sent));
			cfg_wr_en <= 1'b0;
		end else begin
			n_more = $urandom_range(1, 10);
			write_reg(REG_SYS_META_LEN, sent + n_more);
			cfg_wr_en <= 1'b0;
			repeat (n_more)
				send_word($urandom_range(0, 255), $urandom_range(0, 7) == 0);
		end

		send_marker($urandom_range(0, 1));
		for (i = 0; i < app_len; i++)
			send_word($urandom_range(0, 255), $urandom_range(0, 7) == 0);
		send_marker($urandom_range(0, 1));

		// For a clean finish the content length is set to the exact size of the
		// record, so the final chunk end lands right on it.
		if (ending == END_COMPLETE) begin
			settle();
			write_reg(REG_CONTENT_LEN, sent + pay_len + MARKER_LEN);
			cfg_wr_en <= 1'b0;
		end

		for (i = 0; i < pay_len; i++) begin
			if (i == pay_len / 3)
				hold_req = 1'b1;
			if (ending == END_SHORT && i == cut) begin
				// Content length at or below the running total: the next chunk end
				// declares the record short.
				settle();
				write_reg(REG_CONTENT_LEN, $urandom_range(0, 1) ? 0 : $urandom_range(0, sent));
				cfg_wr_en <= 1'b0;
				send_word($urandom_range(0, 255), 1'b1);
				break;
			end
			send_word($urandom_range(0, 255), $urandom_range(0, 7) == 0);
		end

		if (ending == END_COMPLETE) begin
			send_marker(1'b1);
		end else if (ending == END_BAD_MARK) begin
			// A correct prefix of the closing separator, then a wrong byte.
			pre = $urandom_range(0, MARKER_LEN - 1);
			for (i = 0; i < pre; i++)
				send_word(BREAK_TEXT[8*(4-i) +: 8], 1'b0);
			do
				bad = $urandom_range(0, 255);
			while (bad == BREAK_TEXT[8*(4-pre) +: 8]);
			send_word(bad, $urandom_range(0, 1));
		end

		// Trailing bytes: after completion the first one is an error, and from then
		// on everything is discarded and chunk ends are no longer examined.
		repeat (30)
			send_word($urandom_range(0, 255), $urandom_range(0, 2) == 0);

		settle();
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
